// ----- rtl/fpr_pkg.sv -----
// Shared constants, command/status types and helpers for the FIFO page replacement block.
package fpr_pkg;

  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int MAX_FRAMES = 64;
  localparam int FIDX_W     = $clog2(MAX_FRAMES);
  localparam int FCNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CFG_W      = 7;
  localparam int TOT_W      = 32;
  localparam int OUT_W      = 3 + PAGE_W + 3 * TOT_W;
  localparam int OUT_BYTES  = (OUT_W + 7) / 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic search_en;
    logic hit_upd;
    logic fill;
    logic evict_rd;
    logic evict;
    logic load_out;
  } fpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_done;
    logic full;
  } fpr_stat_t;

  function automatic logic [TOT_W-1:0] sat_inc(input logic [TOT_W-1:0] v);
    sat_inc = (v == {TOT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/fpr_ctrl.sv -----
// Controller state machine that sequences search, fill, eviction and result hand-off.
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  fpr_stat_t stat,
  output fpr_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_MISS   = 6'b000100,
    S_EVICT  = 6'b001000,
    S_FINISH = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_en = 1'b1;
        if (stat.match) begin
          cmd.hit_upd = 1'b1;
          state_nxt   = S_FINISH;
        end else if (stat.scan_done) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (!stat.full) begin
          cmd.fill  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          cmd.evict_rd = 1'b1;
          state_nxt    = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/fpr_dp.sv -----
// Datapath: frame page memory, dirty bits, FIFO pointers, totals and result register.
module fpr_dp
  import fpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 in_is_write,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  fpr_cmd_t             cmd,
  output fpr_stat_t            stat,
  output logic [OUT_W-1:0]     result
);

  logic [PAGE_W-1:0]     mem [MAX_FRAMES];
  logic [PAGE_W-1:0]     rd_data_r;
  logic [FIDX_W-1:0]     rd_addr;
  logic                  mem_we;
  logic [FIDX_W-1:0]     mem_waddr;

  logic [PAGE_W-1:0]     page_r;
  logic                  wr_r;
  logic [MAX_FRAMES-1:0] dirty_r, dirty_nxt;
  logic [FCNT_W-1:0]     fill_r, fill_nxt;
  logic [FIDX_W-1:0]     oldest_r, oldest_nxt;
  logic [FCNT_W-1:0]     limit_r, limit_nxt;
  logic [FCNT_W-1:0]     scan_r, scan_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic [FIDX_W-1:0]     cmp_idx_r;
  logic [FIDX_W-1:0]     victim_r;
  logic [FIDX_W-1:0]     victim_slot;
  logic [FCNT_W-1:0]     victim_inc;
  logic [TOT_W-1:0]      acc_r, acc_nxt;
  logic [TOT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic [TOT_W-1:0]      wr_cnt_r, wr_cnt_nxt;
  logic                  hit_r;
  logic                  ev_r;
  logic [PAGE_W-1:0]     ev_page_r;
  logic                  ev_dirty_r;
  logic [OUT_W-1:0]      result_r;
  logic [FCNT_W-1:0]     cfg_limit;

  assign stat.match     = cmp_v_r && (rd_data_r == page_r);
  assign stat.scan_done = (scan_r >= fill_r) && !cmp_v_r;
  assign stat.full      = (fill_r >= limit_r);

  // A stale oldest pointer past the filled region wraps to the first frame.
  assign victim_slot = ({1'b0, oldest_r} >= fill_r) ? '0 : oldest_r;
  assign victim_inc  = {1'b0, victim_r} + 1'b1;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_limit = FCNT_W'(1);
    end else if ({1'b0, cfg_wdata} > (CFG_W + 1)'(MAX_FRAMES)) begin
      cfg_limit = FCNT_W'(MAX_FRAMES);
    end else begin
      cfg_limit = FCNT_W'(cfg_wdata);
    end
  end

  always_comb begin
    rd_addr = cmd.evict_rd ? victim_slot : scan_r[FIDX_W-1:0];
    mem_we  = cmd.fill || cmd.evict;
    mem_waddr = cmd.fill ? fill_r[FIDX_W-1:0] : victim_r;

    dirty_nxt  = dirty_r;
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    limit_nxt  = limit_r;
    scan_nxt   = scan_r;
    cmp_v_nxt  = 1'b0;
    acc_nxt    = acc_r;
    rd_cnt_nxt = rd_cnt_r;
    wr_cnt_nxt = wr_cnt_r;

    if (cmd.start) begin
      scan_nxt = '0;
      acc_nxt  = sat_inc(acc_r);
    end
    if (cmd.search_en && (scan_r < fill_r)) begin
      cmp_v_nxt = 1'b1;
      scan_nxt  = scan_r + 1'b1;
    end
    if (cmd.hit_upd && wr_r) begin
      dirty_nxt[cmp_idx_r] = 1'b1;
    end
    if (cmd.fill) begin
      dirty_nxt[fill_r[FIDX_W-1:0]] = wr_r;
      fill_nxt   = fill_r + 1'b1;
      rd_cnt_nxt = sat_inc(rd_cnt_r);
    end
    if (cmd.evict) begin
      dirty_nxt[victim_r] = wr_r;
      rd_cnt_nxt = sat_inc(rd_cnt_r);
      if (dirty_r[victim_r]) begin
        wr_cnt_nxt = sat_inc(wr_cnt_r);
      end
      oldest_nxt = (victim_inc >= fill_r) ? '0 : victim_inc[FIDX_W-1:0];
    end
    if (cfg_wr_en) begin
      limit_nxt  = cfg_limit;
      fill_nxt   = '0;
      oldest_nxt = '0;
      dirty_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= page_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r  <= '0;
      fill_r   <= '0;
      oldest_r <= '0;
      limit_r  <= FCNT_W'(MAX_FRAMES);
      scan_r   <= '0;
      cmp_v_r  <= 1'b0;
      acc_r    <= '0;
      rd_cnt_r <= '0;
      wr_cnt_r <= '0;
    end else begin
      dirty_r  <= dirty_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      limit_r  <= limit_nxt;
      scan_r   <= scan_nxt;
      cmp_v_r  <= cmp_v_nxt;
      acc_r    <= acc_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      wr_cnt_r <= wr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_r[FIDX_W-1:0];
    if (cmd.start) begin
      page_r     <= in_address[ADDR_W-1:PAGE_SHIFT];
      wr_r       <= in_is_write;
      hit_r      <= 1'b0;
      ev_r       <= 1'b0;
      ev_page_r  <= '0;
      ev_dirty_r <= 1'b0;
    end
    if (cmd.hit_upd) begin
      hit_r <= 1'b1;
    end
    if (cmd.evict_rd) begin
      victim_r <= victim_slot;
    end
    if (cmd.evict) begin
      ev_r       <= 1'b1;
      ev_page_r  <= rd_data_r;
      ev_dirty_r <= dirty_r[victim_r];
    end
    if (cmd.load_out) begin
      result_r <= {wr_cnt_r, rd_cnt_r, acc_r, ev_dirty_r, ev_page_r, ev_r, hit_r};
    end
  end

  assign result = result_r;

endmodule

// ----- rtl/fifo_page_replacement.sv -----
// Top level of the FIFO page replacement block with dirty tracking.
//
// Input channel (in_*): one memory access per transaction, the byte address in
// in_tdata and the write flag in in_tuser. Result channel (out_*): one result
// per access with hit and eviction details and the three running totals.
// The configuration port sets the number of usable frames (0 acts as 1, values
// above 64 act as 64) and empties the frame table; the totals are kept.
//
// Items are handled one at a time. After acceptance the controller scans the
// filled frames through the page memory's registered read port, one frame per
// cycle. A hit in a frame ends the search with a result; on a miss the page
// fills the next free frame, or, once the usable frames (at most 64) are all
// filled, replaces the oldest frame, whose page is read out first. in_tready is
// high only while the block is idle, so the next access is taken in the cycle
// after the result is loaded. Reset clears the frame table and totals and sets
// 64 usable frames; there is no clearing pass. A stalled receiver holds the
// result in the output register; a finished item waits in the finish state
// until the register frees up.
module fifo_page_replacement
  import fpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ADDR_W-1:0]      in_tdata,   // [31:0] address
  input  logic                   in_tuser,   // [0] is_write
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] hit, [1] evicted, [21:2] evicted_page, [22] evicted_dirty,
  // [54:23] access_total, [86:55] disk_reads, [118:87] disk_writes, [119] zero
  output logic [OUT_BYTES*8-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  fpr_cmd_t         cmd;
  fpr_stat_t        stat;
  logic [OUT_W-1:0] result;

  fpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  fpr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_address  (in_tdata),
    .in_is_write (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

  assign out_tdata = {{(OUT_BYTES*8-OUT_W){1'b0}}, result};

  // A result is never both a hit and an eviction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and eviction reported together");

  // Without an eviction the victim fields read zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> (out_tdata[21:2] == '0) && !out_tdata[22])
    else $error("victim fields set without eviction");

  // Every write-back comes with a load, so writes never exceed reads.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[118:87] <= out_tdata[86:55]))
    else $error("disk writes exceed disk reads");

  // A new access is never taken while the controller is busy with one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("access accepted twice in a row");

endmodule
